### src/hhbl_pkg.sv
package hhbl_pkg;

  // message and field sizes
  localparam int MAX_MESSAGE_BYTES = 524288;
  localparam int POS_W             = 20;
  localparam int LEN_W             = 31;
  localparam int KEY_LEN           = 16;
  localparam int KEY_W             = $clog2(KEY_LEN);
  localparam int IN_DATA_W         = 8;
  localparam int RESULT_W          = POS_W + 1 + LEN_W + 1 + 1;
  localparam int OUT_DATA_W        = ((RESULT_W + 7) / 8) * 8;

  // position stops advancing at the smaller of the message limit and the counter cap
  localparam int POS_CAP_I   = (1 << POS_W) - 1;
  localparam int POS_LIMIT_I = (MAX_MESSAGE_BYTES < POS_CAP_I) ? MAX_MESSAGE_BYTES : POS_CAP_I;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);
  localparam logic [LEN_W-1:0] LEN_MAX   = '1;

  // characters of interest
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_KEY0 = 8'h43;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // length field phase
  typedef enum logic [2:0] {
    PHASE_SEARCH = 3'b001,
    PHASE_DIGITS = 3'b010,
    PHASE_DONE   = 3'b100
  } phase_t;

  // one registered input beat
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [IN_DATA_W-1:0] data;
  } beat_t;

  // one result, body_start in the lowest bits
  typedef struct packed {
    logic             length_overflow;
    logic             length_found;
    logic [LEN_W-1:0] content_length;
    logic             header_end_found;
    logic [POS_W-1:0] body_start;
  } result_t;

  // characters of the key text "Content-Length: "
  function automatic logic [7:0] key_char(input logic [KEY_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3A;
      4'd15:   c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### src/http_header_body_locator.sv
// path: a last beat moves from the input register into the result register
// throughput: one byte beat per cycle; the input register stalls only when a last
//   beat meets a full result register that is not being drained
// reset: synchronous active-low rst_n clears both stage valids and all matcher state;
//   after each last beat the matchers return to the reset state by themselves
module http_header_body_locator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hhbl_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                            in_tlast,   // last_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [19:0] body_start, [20] header_end_found, [51:21] content_length,
  // [52] length_found, [53] length_overflow, [55:54] zero
  output logic [hhbl_pkg::OUT_DATA_W-1:0] out_tdata
);

  hhbl_pkg::beat_t   beat;
  hhbl_pkg::result_t result;
  logic              consume;
  logic              result_load;
  logic              out_free;

  // input register
  hhbl_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .consume   (consume),
    .beat      (beat)
  );

  // terminator and length matchers
  hhbl_scanner u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat        (beat),
    .out_free    (out_free),
    .consume     (consume),
    .result_load (result_load),
    .result      (result)
  );

  // result register
  hhbl_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .result_load (result_load),
    .result      (result),
    .out_free    (out_free),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

### src/hhbl_in_stage.sv
module hhbl_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hhbl_pkg::IN_DATA_W-1:0] in_tdata,  // [7:0] data_byte
  input  logic                          in_tlast,
  input  logic                          consume,
  output hhbl_pkg::beat_t               beat
);

  hhbl_pkg::beat_t beat_r;
  hhbl_pkg::beat_t beat_nxt;

  // stage is free when empty or when its beat moves on this cycle
  assign in_tready = !beat_r.valid || consume;

  // capture next beat
  always_comb begin
    beat_nxt = beat_r;
    if (in_tready) begin
      beat_nxt.valid = in_tvalid;
      beat_nxt.last  = in_tlast;
      beat_nxt.data  = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else begin
      beat_r.valid <= beat_nxt.valid;
    end
    beat_r.last <= beat_nxt.last;
    beat_r.data <= beat_nxt.data;
  end

  assign beat = beat_r;

endmodule

### src/hhbl_scanner.sv
module hhbl_scanner (
  input  logic              clk,
  input  logic              rst_n,
  input  hhbl_pkg::beat_t   beat,
  input  logic              out_free,
  output logic              consume,
  output logic              result_load,
  output hhbl_pkg::result_t result
);

  logic [hhbl_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]                 term_r, term_nxt;
  logic [hhbl_pkg::POS_W-1:0] held_r, held_nxt;
  logic                       seen_r, seen_nxt;
  logic [hhbl_pkg::KEY_W-1:0] key_r, key_nxt;
  hhbl_pkg::phase_t           phase_r, phase_nxt;
  logic [hhbl_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;

  logic [7:0]                 b;
  logic [hhbl_pkg::LEN_W+3:0] acc;
  logic [3:0]                 digit;

  assign b = beat.data;

  // a beat without a result never waits; a last beat waits for the result register
  assign consume     = beat.valid && (!beat.last || out_free);
  assign result_load = consume && beat.last;

  // decimal accumulate: value * 10 + digit
  assign digit = 4'(b - hhbl_pkg::CHAR_ZERO);
  assign acc   = {1'b0, len_r, 3'b000} + {3'b000, len_r, 1'b0} + {31'd0, digit};

  // matcher next state
  always_comb begin
    pos_nxt   = pos_r;
    term_nxt  = term_r;
    held_nxt  = held_r;
    seen_nxt  = seen_r;
    key_nxt   = key_r;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    result    = '0;

    if (consume && (pos_r < hhbl_pkg::POS_LIMIT)) begin
      // blank line terminator
      if (b == (term_r[0] ? hhbl_pkg::CHAR_LF : hhbl_pkg::CHAR_CR)) begin
        if (term_r == 2'd3) begin
          seen_nxt = 1'b1;
          held_nxt = pos_r + 1'b1;
          term_nxt = 2'd2;
        end else begin
          term_nxt = term_r + 2'd1;
        end
      end else begin
        term_nxt = (b == hhbl_pkg::CHAR_CR) ? 2'd1 : 2'd0;
      end

      // length key and digits
      case (phase_r)
        hhbl_pkg::PHASE_SEARCH: begin
          if (b == hhbl_pkg::key_char(key_r)) begin
            if (key_r == hhbl_pkg::KEY_W'(hhbl_pkg::KEY_LEN - 1)) begin
              phase_nxt = hhbl_pkg::PHASE_DIGITS;
              len_nxt   = '0;
              key_nxt   = '0;
            end else begin
              key_nxt = key_r + 1'b1;
            end
          end else begin
            key_nxt = (b == hhbl_pkg::CHAR_KEY0) ? hhbl_pkg::KEY_W'(1) : '0;
          end
        end
        hhbl_pkg::PHASE_DIGITS: begin
          if (b inside {[hhbl_pkg::CHAR_ZERO:hhbl_pkg::CHAR_NINE]}) begin
            if (acc > {4'd0, hhbl_pkg::LEN_MAX}) begin
              len_nxt = hhbl_pkg::LEN_MAX;
              ovf_nxt = 1'b1;
            end else begin
              len_nxt = acc[hhbl_pkg::LEN_W-1:0];
            end
          end else begin
            phase_nxt = hhbl_pkg::PHASE_DONE;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      pos_nxt = pos_r + 1'b1;
    end

    // last beat: report and start over
    if (result_load) begin
      result.body_start       = held_nxt;
      result.header_end_found = seen_nxt;
      result.content_length   = len_nxt;
      result.length_found     = (phase_nxt != hhbl_pkg::PHASE_SEARCH);
      result.length_overflow  = ovf_nxt;
      pos_nxt   = '0;
      term_nxt  = '0;
      held_nxt  = '0;
      seen_nxt  = 1'b0;
      key_nxt   = '0;
      phase_nxt = hhbl_pkg::PHASE_SEARCH;
      len_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      term_r  <= '0;
      held_r  <= '0;
      seen_r  <= 1'b0;
      key_r   <= '0;
      phase_r <= hhbl_pkg::PHASE_SEARCH;
      len_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      term_r  <= term_nxt;
      held_r  <= held_nxt;
      seen_r  <= seen_nxt;
      key_r   <= key_nxt;
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

### src/hhbl_out_stage.sv
module hhbl_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            result_load,
  input  hhbl_pkg::result_t               result,
  output logic                            out_free,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hhbl_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic              valid_r, valid_nxt;
  hhbl_pkg::result_t result_r, result_nxt;

  // register is free when empty or being drained
  assign out_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt  = valid_r;
    result_nxt = result_r;
    if (result_load) begin
      valid_nxt  = 1'b1;
      result_nxt = result;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    result_r <= result_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(hhbl_pkg::OUT_DATA_W - hhbl_pkg::RESULT_W)'(0), result_r};

endmodule

### src/hhbl_checker.sv
module hhbl_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hhbl_pkg::OUT_DATA_W-1:0] out_tdata
);

  hhbl_pkg::result_t res;

  assign res = out_tdata[hhbl_pkg::RESULT_W-1:0];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // overflow only after the key was found, and then the value is saturated
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.length_overflow |->
      res.length_found && (res.content_length == hhbl_pkg::LEN_MAX))
    else $error("overflow without found key or saturated value");

  // no key means zero length
  a_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.length_found |-> res.content_length == '0)
    else $error("length reported without key");

  // no terminator means body start zero, otherwise past the first four bytes
  a_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (res.header_end_found ? (res.body_start >= hhbl_pkg::POS_W'(4))
                            : (res.body_start == '0)))
    else $error("body start inconsistent with terminator flag");

  // pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[hhbl_pkg::OUT_DATA_W-1:hhbl_pkg::RESULT_W] == '0)
    else $error("pad bits set");

endmodule

bind http_header_body_locator hhbl_checker u_hhbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### bench/tb_http_header_body_locator.sv
module tb_http_header_body_locator;

  // expected results of the locator and their comparison with the output beats
  class locator_scoreboard;
    localparam logic [127:0] KEY_TEXT = "Content-Length: ";

    hhbl_pkg::result_t          pending_results[$];
    int                         errors;
    logic [hhbl_pkg::POS_W-1:0] pos;
    logic [hhbl_pkg::POS_W-1:0] held_start;
    logic [1:0]                 crlf_state;
    logic                       blank_line_seen;
    int                         key_idx;
    hhbl_pkg::phase_t           phase;
    logic [hhbl_pkg::LEN_W-1:0] len_acc;
    logic                       len_sat;

    function new();
      errors = 0;
      clear_message();
    endfunction

    function void clear_message();
      pos             = '0;
      held_start      = '0;
      crlf_state      = '0;
      blank_line_seen = 1'b0;
      key_idx         = 0;
      phase           = hhbl_pkg::PHASE_SEARCH;
      len_acc         = '0;
      len_sat         = 1'b0;
    endfunction

    // advance the matchers by one accepted byte, queue a result on the last one
    function void note_byte(logic [7:0] b, logic last);
      hhbl_pkg::result_t r;
      logic [7:0]        want;
      longint unsigned   grown;
      if (pos < hhbl_pkg::POS_LIMIT) begin
        // blank-line terminator, a trailing cr lf counts toward the next one
        want = crlf_state[0] ? hhbl_pkg::CHAR_LF : hhbl_pkg::CHAR_CR;
        if (b == want) begin
          if (crlf_state == 2'd3) begin
            blank_line_seen = 1'b1;
            held_start      = pos + 1'b1;
            crlf_state      = 2'd2;
          end else begin
            crlf_state = crlf_state + 1'b1;
          end
        end else begin
          crlf_state = (b == hhbl_pkg::CHAR_CR) ? 2'd1 : 2'd0;
        end
        // key search, then decimal digits
        case (phase)
          hhbl_pkg::PHASE_SEARCH: begin
            if (b == KEY_TEXT[127 - 8*key_idx -: 8]) begin
              key_idx++;
              if (key_idx == hhbl_pkg::KEY_LEN) begin
                phase   = hhbl_pkg::PHASE_DIGITS;
                len_acc = '0;
                key_idx = 0;
              end
            end else begin
              key_idx = (b == hhbl_pkg::CHAR_KEY0) ? 1 : 0;
            end
          end
          hhbl_pkg::PHASE_DIGITS: begin
            if (b >= hhbl_pkg::CHAR_ZERO && b <= hhbl_pkg::CHAR_NINE) begin
              grown = longint'(len_acc) * 10 + longint'(b - hhbl_pkg::CHAR_ZERO);
              if (grown > longint'(hhbl_pkg::LEN_MAX)) begin
                len_acc = hhbl_pkg::LEN_MAX;
                len_sat = 1'b1;
              end else begin
                len_acc = grown[hhbl_pkg::LEN_W-1:0];
              end
            end else begin
              phase = hhbl_pkg::PHASE_DONE;
            end
          end
          default: ;
        endcase
        pos = pos + 1'b1;
      end
      if (last) begin
        r.body_start       = held_start;
        r.header_end_found = blank_line_seen;
        r.content_length   = len_acc;
        r.length_found     = (phase != hhbl_pkg::PHASE_SEARCH);
        r.length_overflow  = len_sat;
        pending_results.push_back(r);
        clear_message();
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // compare one output beat with the oldest expected result
    task check_result(logic [hhbl_pkg::OUT_DATA_W-1:0] beat);
      hhbl_pkg::result_t got;
      hhbl_pkg::result_t want;
      got = beat[hhbl_pkg::RESULT_W-1:0];
      if (pending_results.size() == 0) begin
        report($sformatf("result beat %h with none expected", beat));
        return;
      end
      want = pending_results.pop_front();
      if (got.body_start != want.body_start)
        report($sformatf("body_start %0d, expected %0d", got.body_start, want.body_start));
      if (got.header_end_found != want.header_end_found)
        report($sformatf("header_end_found %0b, expected %0b",
                         got.header_end_found, want.header_end_found));
      if (got.content_length != want.content_length)
        report($sformatf("content_length %0d, expected %0d",
                         got.content_length, want.content_length));
      if (got.length_found != want.length_found)
        report($sformatf("length_found %0b, expected %0b",
                         got.length_found, want.length_found));
      if (got.length_overflow != want.length_overflow)
        report($sformatf("length_overflow %0b, expected %0b",
                         got.length_overflow, want.length_overflow));
      if (beat[hhbl_pkg::OUT_DATA_W-1:hhbl_pkg::RESULT_W] != '0)
        report($sformatf("padding bits %b not zero",
                         beat[hhbl_pkg::OUT_DATA_W-1:hhbl_pkg::RESULT_W]));
    endtask
  endclass

  localparam string LENGTH_KEY = "Content-Length: ";

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [hhbl_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [hhbl_pkg::OUT_DATA_W-1:0] out_tdata;

  locator_scoreboard sb;
  logic [7:0]        frame_bytes[$];
  int                send_idle_pct;
  int                recv_stall_pct;
  int                beats_sent;
  int                messages_sent;

  http_header_body_locator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // receiver stalls at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result beats
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // message text helpers
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    frame_bytes.push_back(hhbl_pkg::CHAR_CR);
    frame_bytes.push_back(hhbl_pkg::CHAR_LF);
  endfunction

  function automatic void add_digits(int n);
    repeat (n) frame_bytes.push_back(hhbl_pkg::CHAR_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void add_value();
    int r;
    r = $urandom_range(9);
    case (r)
      0:       ;
      1:       add_text("2147483647");
      2:       add_text("2147483648");
      3:       add_digits($urandom_range(14, 10));
      default: add_digits($urandom_range(5, 1));
    endcase
  endfunction

  function automatic void add_filler_line();
    add_text("X-A: ");
    repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom_range(126, 32)));
    add_crlf();
  endfunction

  // length header, correct or damaged; returns 1 when the message ends in its digits
  function automatic bit add_length_line();
    int v;
    int cut;
    v = $urandom_range(9);
    case (v)
      6: begin
        cut = $urandom_range(15, 1);
        add_text(LENGTH_KEY.substr(0, cut - 1));
        frame_bytes.push_back($urandom_range(1) ? 8'h00 : 8'($urandom));
        add_text(LENGTH_KEY.substr(cut, hhbl_pkg::KEY_LEN - 1));
        add_value();
      end
      7: begin
        add_text("content-length: ");
        add_value();
      end
      8: begin
        add_text("CContent-Length: ");
        add_value();
      end
      9: begin
        add_text(LENGTH_KEY);
        add_digits($urandom_range(5, 1));
        return 1'b1;
      end
      default: begin
        add_text(LENGTH_KEY);
        add_value();
      end
    endcase
    add_crlf();
    return 1'b0;
  endfunction

  function automatic void build_random_message();
    int kind;
    bit ends_in_digits;
    frame_bytes.delete();
    ends_in_digits = 1'b0;
    kind = $urandom_range(99);
    if (kind < 12) begin
      // noise
      repeat ($urandom_range(40, 1)) frame_bytes.push_back(8'($urandom));
    end else begin
      if ($urandom_range(2) == 0) begin
        add_text("HTTP/1.1 200 OK");
        add_crlf();
      end
      if ($urandom_range(1) == 0) add_filler_line();
      if ($urandom_range(9) < 8) ends_in_digits = add_length_line();
      if (!ends_in_digits) begin
        if ($urandom_range(2) == 0) add_filler_line();
        if (frame_bytes.size() == 0) add_crlf();
        kind = $urandom_range(9);
        if (kind < 7) begin
          add_crlf();
        end else if (kind == 7) begin
          frame_bytes.push_back(hhbl_pkg::CHAR_CR);
          frame_bytes.push_back(8'h78);
        end
        // body, sometimes with another blank line inside
        repeat ($urandom_range(10)) frame_bytes.push_back(8'($urandom));
        if ($urandom_range(4) == 0) begin
          add_crlf();
          add_crlf();
          repeat ($urandom_range(3)) frame_bytes.push_back(8'($urandom));
        end
      end
    end
    if (frame_bytes.size() == 0) frame_bytes.push_back(8'($urandom));
  endfunction

  // one byte beat, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_message();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    messages_sent++;
  endtask

  // hard limit on the run
  initial begin
    #(64'd12 * 64'd4000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int beats_mark;
    int msgs_mark;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    beats_sent     = 0;
    messages_sent  = 0;
    sb             = new();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: lone extreme bytes
    frame_bytes = '{8'h00};
    send_message();
    frame_bytes = '{8'hFF};
    send_message();
    // chained blank lines, the last one wins
    frame_bytes.delete();
    add_crlf();
    add_crlf();
    add_crlf();
    send_message();
    // largest value, then one past it
    frame_bytes.delete();
    add_text({LENGTH_KEY, "2147483647"});
    add_crlf();
    add_crlf();
    add_text("ab");
    send_message();
    frame_bytes.delete();
    add_text({LENGTH_KEY, "2147483648"});
    add_crlf();
    add_crlf();
    send_message();
    // key with no digits
    frame_bytes.delete();
    add_text(LENGTH_KEY);
    add_crlf();
    add_crlf();
    send_message();
    // key broken by a nul
    frame_bytes.delete();
    add_text("Content-Len");
    frame_bytes.push_back(8'h00);
    add_text("gth: 5");
    add_crlf();
    add_crlf();
    send_message();
    // digit field still open on the last byte
    frame_bytes.delete();
    add_text({LENGTH_KEY, "42"});
    send_message();
    // restart of the key on a repeated c, long overflowing value
    frame_bytes.delete();
    add_text({"C", LENGTH_KEY, "99999999999"});
    add_crlf();
    add_crlf();
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h80);
    send_message();

    // random messages over the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      beats_mark = beats_sent;
      msgs_mark  = messages_sent;
      while (beats_sent - beats_mark < 180 || messages_sent - msgs_mark < 4) begin
        build_random_message();
        send_message();
      end
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // drain
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
